FILE: design/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and codes of the priority event dispatcher: request and
// response words, queue and handler entries, controller command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package ped_pkg;

   localparam logic [1:0] CMD_REGISTER = 2'd0;
   localparam logic [1:0] CMD_TRIGGER  = 2'd1;
   localparam logic [1:0] CMD_DISPATCH = 2'd2;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_FULL       = 2'd1;
   localparam logic [1:0] STS_EMPTY      = 2'd2;
   localparam logic [1:0] STS_NO_HANDLER = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] event_id;
      logic [7:0]  priority_req;
      logic [15:0] arg_tag;
      logic [15:0] handler_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        dispatched;
      logic [15:0] out_event_id;
      logic [7:0]  out_priority;
      logic [15:0] out_arg_tag;
      logic [15:0] out_handler_tag;
      logic [4:0]  pending_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  pri;
      logic [15:0] arg;
   } qent_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] tag;
   } hent_type;

   typedef enum logic [1:0] {
      PH_QSCAN,
      PH_QSHIFT,
      PH_HSCAN
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QSCAN,
      S_QSHIFT,
      S_HSCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic      load;
      logic      start;
      phase_type start_phase;
      logic      run;
      phase_type run_phase;
      logic      commit;
   } ctl_type;

   typedef struct packed {
      logic dispatch_go;
      logic walk_done;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: design/priority_event_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// priority_event_dispatcher_unit
// Handler table and priority-ordered event queue with a dispatch command.
//
// One request word on req_ (valid/ready) gives exactly one response word on
// rsp_ (valid/ready). Register and trigger append an entry; dispatch takes
// the first entry of highest priority, closes the gap and looks up the last
// handler with a matching id (slot 0 when none matches).
// Register, trigger and dispatch on an empty queue skip the walks. Dispatch
// on a non-empty queue scans the pending events, then moves the entries
// behind the chosen one forward, then scans the handlers, one entry per
// cycle through the single read port of each memory.
// A new request is taken as soon as the sequencer is idle, while the last
// response may still wait in its output register. A stalled receiver holds
// the response; the next request then waits at its final step.
// Reset empties queue and handler table and drops any held response.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_event_dispatcher_unit #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int HANDLER_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ped_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ped_pkg::rsp_type      rsp_data
);
   import ped_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   ped_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   ped_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .HANDLER_DEPTH (HANDLER_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/ped_controller.sv
// ----------------------------------------------------------------------------
// ped_controller
// Sequencer of the dispatcher: takes a request word, runs queue scan, queue
// shift and handler scan if a dispatch finds events, then commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ped_pkg::stat_type stat,
   output ped_pkg::ctl_type      ctl
);
   import ped_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      ctl.load        = 1'b0;
      ctl.start       = 1'b0;
      ctl.start_phase = PH_QSCAN;
      ctl.run         = 1'b0;
      ctl.run_phase   = PH_QSCAN;
      ctl.commit      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               if (stat.dispatch_go) begin
                  ctl.start       = 1'b1;
                  ctl.start_phase = PH_QSCAN;
                  state_in        = S_QSCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_QSCAN: begin
            ctl.run       = 1'b1;
            ctl.run_phase = PH_QSCAN;
            if (stat.walk_done) begin
               ctl.start       = 1'b1;
               ctl.start_phase = PH_QSHIFT;
               state_in        = S_QSHIFT;
            end
         end
         S_QSHIFT: begin
            ctl.run       = 1'b1;
            ctl.run_phase = PH_QSHIFT;
            if (stat.walk_done) begin
               ctl.start       = 1'b1;
               ctl.start_phase = PH_HSCAN;
               state_in        = S_HSCAN;
            end
         end
         S_HSCAN: begin
            ctl.run       = 1'b1;
            ctl.run_phase = PH_HSCAN;
            if (stat.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               ctl.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/ped_datapath.sv
// ----------------------------------------------------------------------------
// ped_datapath
// Queue and handler memories, totals, walk counter with registered reads,
// best-entry and handler-match tracking, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_datapath #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int HANDLER_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ped_pkg::ctl_type  ctl,
   output ped_pkg::stat_type      stat,
   input  wire ped_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ped_pkg::rsp_type       rsp_data
);
   import ped_pkg::*;

   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int HW  = (HANDLER_DEPTH > 1) ? $clog2(HANDLER_DEPTH) : 1;
   localparam int PTW = $clog2(QUEUE_DEPTH + 1);
   localparam int HTW = $clog2(HANDLER_DEPTH + 1);
   localparam int CW  = (PTW > HTW) ? PTW : HTW;

   qent_type qmem [QUEUE_DEPTH];
   hent_type hmem [HANDLER_DEPTH];

   logic [PTW-1:0] pt_ff, pt_in;
   logic [HTW-1:0] ht_ff, ht_in;
   req_type        req_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff;

   logic [CW-1:0]  idx_ff, end_ff, pidx_ff, best_idx_ff;
   logic [CW-1:0]  start_val, end_val, shift_addr;
   logic           pvld_ff;
   logic           issue;
   qent_type       q_rd_ff, best_ent_ff;
   hent_type       h_rd_ff;
   logic [15:0]    hit_tag_ff;
   logic           shift_we, trig_we, reg_we;
   logic [31:0]    pc_wide;

   // walk range
   always_comb begin
      start_val = '0;
      end_val   = '0;
      unique case (ctl.start_phase)
         PH_QSCAN: begin
            start_val = '0;
            end_val   = CW'(pt_ff);
         end
         PH_QSHIFT: begin
            start_val = best_idx_ff + CW'(1);
            end_val   = CW'(pt_ff);
         end
         PH_HSCAN: begin
            start_val = '0;
            end_val   = CW'(ht_ff);
         end
         default: begin
            start_val = '0;
            end_val   = '0;
         end
      endcase
   end

   assign issue      = ctl.run && !ctl.start && (idx_ff < end_ff);
   assign shift_addr = pidx_ff - CW'(1);
   assign shift_we   = ctl.run && (ctl.run_phase == PH_QSHIFT) && pvld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else if (ctl.start) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         idx_ff <= start_val;
         end_ff <= end_val;
      end else if (issue) begin
         idx_ff  <= idx_ff + CW'(1);
         pidx_ff <= idx_ff;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (issue) begin
         if (ctl.run_phase == PH_HSCAN) begin
            h_rd_ff <= hmem[idx_ff[HW-1:0]];
         end else begin
            q_rd_ff <= qmem[idx_ff[QW-1:0]];
         end
      end
   end

   // track best entry and matching handler
   always_ff @(posedge clock) begin
      if (ctl.run && pvld_ff) begin
         unique case (ctl.run_phase)
            PH_QSCAN: begin
               if ((pidx_ff == '0) || (q_rd_ff.pri > best_ent_ff.pri)) begin
                  best_ent_ff <= q_rd_ff;
                  best_idx_ff <= pidx_ff;
               end
            end
            PH_HSCAN: begin
               if ((pidx_ff == '0) || (h_rd_ff.id == best_ent_ff.id)) begin
                  hit_tag_ff <= h_rd_ff.tag;
               end
            end
            PH_QSHIFT: begin
            end
            default: begin
            end
         endcase
      end
   end

   // commit
   always_comb begin
      pt_in   = pt_ff;
      ht_in   = ht_ff;
      trig_we = 1'b0;
      reg_we  = 1'b0;
      rsp_in  = '0;
      unique case (req_ff.command)
         CMD_REGISTER: begin
            if (ht_ff >= HTW'(HANDLER_DEPTH)) begin
               rsp_in.status = STS_FULL;
            end else begin
               reg_we = 1'b1;
               ht_in  = ht_ff + HTW'(1);
            end
         end
         CMD_TRIGGER: begin
            if (pt_ff >= PTW'(QUEUE_DEPTH)) begin
               rsp_in.status = STS_FULL;
            end else begin
               trig_we = 1'b1;
               pt_in   = pt_ff + PTW'(1);
            end
         end
         CMD_DISPATCH: begin
            if (pt_ff == '0) begin
               rsp_in.status = STS_EMPTY;
            end else begin
               pt_in                  = pt_ff - PTW'(1);
               rsp_in.dispatched      = 1'b1;
               rsp_in.out_event_id    = best_ent_ff.id;
               rsp_in.out_priority    = best_ent_ff.pri;
               rsp_in.out_arg_tag     = best_ent_ff.arg;
               if (ht_ff == '0) begin
                  rsp_in.status = STS_NO_HANDLER;
               end else begin
                  rsp_in.out_handler_tag = hit_tag_ff;
               end
            end
         end
         default: begin
         end
      endcase
      pc_wide              = 32'(pt_in);
      rsp_in.pending_count = pc_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (shift_we) begin
         qmem[shift_addr[QW-1:0]] <= q_rd_ff;
      end else if (ctl.commit && trig_we) begin
         qmem[pt_ff[QW-1:0]] <= '{id: req_ff.event_id, pri: req_ff.priority_req,
                                  arg: req_ff.arg_tag};
      end
      if (ctl.commit && reg_we) begin
         hmem[ht_ff[HW-1:0]] <= '{id: req_ff.event_id, tag: req_ff.handler_tag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff        <= '0;
         ht_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.commit) begin
            pt_ff        <= pt_in;
            ht_ff        <= ht_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      if (ctl.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.dispatch_go = (req_data.command == CMD_DISPATCH) && (pt_ff != '0);
   assign stat.walk_done   = (idx_ff >= end_ff) && !pvld_ff;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pt_bound: assert property (@(posedge clock) disable iff (reset)
      pt_ff <= PTW'(QUEUE_DEPTH))
      else $error("pending total beyond queue depth");

   a_ht_bound: assert property (@(posedge clock) disable iff (reset)
      ht_ff <= HTW'(HANDLER_DEPTH))
      else $error("handler total beyond table depth");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      shift_we |-> (pidx_ff != '0) && (pidx_ff < CW'(pt_ff)))
      else $error("queue shift outside occupied entries");

endmodule

`default_nettype wire
